FILE: rtl/grid_bfs_path_finder_top_assert.svh
// Assertion macros for the grid path finder checker.
`ifndef GRID_BFS_PATH_FINDER_TOP_ASSERT_SVH
`define GRID_BFS_PATH_FINDER_TOP_ASSERT_SVH

// Clocked property, ignored while reset is asserted.
`define GBPF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A signal keeps its value in the cycle after cond.
`define GBPF_ASSERT_HOLD(lbl, cond, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) cond |=> $stable(sig)) else $error(msg);

`endif

FILE: rtl/gbpf_pkg.sv
package gbpf_pkg;

	localparam int GRID_W     = 32;
	localparam int GRID_H     = 32;
	localparam int FIFO_DEPTH = 1024;
	localparam int WALL_ROWS  = 32;
	localparam int WALL_COLS  = 32;

	typedef enum logic [1:0] {
		REQ_LOAD   = 2'd0,
		REQ_SEARCH = 2'd1,
		REQ_STEP   = 2'd2
	} req_kind_t;

	typedef enum logic [1:0] {
		DIR_UP    = 2'd0,
		DIR_LEFT  = 2'd1,
		DIR_DOWN  = 2'd2,
		DIR_RIGHT = 2'd3
	} dir_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [4:0]  row_index;
		logic [31:0] wall_row;
		logic [5:0]  start_x;
		logic [5:0]  start_y;
		logic [5:0]  target_x;
		logic [5:0]  target_y;
	} req_t;

	typedef struct packed {
		logic        found;
		logic        step_valid;
		logic [5:0]  pos_x;
		logic [5:0]  pos_y;
		logic [5:0]  prev_x;
		logic [5:0]  prev_y;
		logic [10:0] steps_left;
	} rsp_t;

	typedef struct packed {
		logic latch;
		logic load_row;
		logic clr_step;
		logic start_rd;
		logic push_start;
		logic pop_take;
		logic nb_issue;
		logic nb_mark;
		logic nb_next;
		logic trace_start;
		logic trace_take;
		logic step_issue;
		logic step_take;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       coords_bad;
		logic       clr_last;
		logic       target_wall;
		logic       fifo_empty;
		logic       target_hit;
		logic       nb_oob;
		logic       dir_last;
		logic       trace_done;
		logic       trace_oob;
		logic       path_empty;
	} status_t;

endpackage

FILE: rtl/gbpf_ram.sv
module gbpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/gbpf_ctrl.sv
module gbpf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	input  gbpf_pkg::status_t status,
	output gbpf_pkg::cmd_t    cmd
);

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_DISP  = 13'b0000000000010,
		S_STEP  = 13'b0000000000100,
		S_CLR   = 13'b0000000001000,
		S_TCHK  = 13'b0000000010000,
		S_SWR   = 13'b0000000100000,
		S_POP   = 13'b0000001000000,
		S_PCHK  = 13'b0000010000000,
		S_NRD   = 13'b0000100000000,
		S_NCHK  = 13'b0001000000000,
		S_TRD   = 13'b0010000000000,
		S_TCALC = 13'b0100000000000,
		S_DONE  = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign req_stall = (state_q != S_IDLE) || out_valid_q;
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid && !req_stall) begin
					cmd.latch = 1'b1;
					state_d   = S_DISP;
				end
			end
			S_DISP: begin
				unique case (status.req_type)
					gbpf_pkg::REQ_LOAD: begin
						cmd.load_row = 1'b1;
						state_d      = S_DONE;
					end
					gbpf_pkg::REQ_SEARCH: begin
						state_d = status.coords_bad ? S_DONE : S_CLR;
					end
					gbpf_pkg::REQ_STEP: begin
						if (status.path_empty) begin
							state_d = S_DONE;
						end else begin
							cmd.step_issue = 1'b1;
							state_d        = S_STEP;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_STEP: begin
				cmd.step_take = 1'b1;
				state_d       = S_DONE;
			end
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (status.clr_last) begin
					state_d = S_TCHK;
				end
			end
			S_TCHK: begin
				if (status.target_wall) begin
					state_d = S_DONE;
				end else begin
					cmd.start_rd = 1'b1;
					state_d      = S_SWR;
				end
			end
			S_SWR: begin
				cmd.push_start = 1'b1;
				state_d        = S_POP;
			end
			S_POP: begin
				state_d = status.fifo_empty ? S_DONE : S_PCHK;
			end
			S_PCHK: begin
				if (status.target_hit) begin
					cmd.trace_start = 1'b1;
					state_d         = S_TRD;
				end else begin
					cmd.pop_take = 1'b1;
					state_d      = S_NRD;
				end
			end
			S_NRD: begin
				if (status.nb_oob) begin
					cmd.nb_next = 1'b1;
					state_d     = status.dir_last ? S_POP : S_NRD;
				end else begin
					cmd.nb_issue = 1'b1;
					state_d      = S_NCHK;
				end
			end
			S_NCHK: begin
				cmd.nb_mark = 1'b1;
				cmd.nb_next = 1'b1;
				state_d     = status.dir_last ? S_POP : S_NRD;
			end
			S_TRD: begin
				state_d = status.trace_done ? S_DONE : S_TCALC;
			end
			S_TCALC: begin
				if (status.trace_oob) begin
					state_d = S_DONE;
				end else begin
					cmd.trace_take = 1'b1;
					state_d        = S_TRD;
				end
			end
			S_DONE: begin
				cmd.out_load = 1'b1;
				state_d      = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/gbpf_dp.sv
module gbpf_dp #(
	parameter int GRID_W     = gbpf_pkg::GRID_W,
	parameter int GRID_H     = gbpf_pkg::GRID_H,
	parameter int FIFO_DEPTH = gbpf_pkg::FIFO_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gbpf_pkg::cmd_t    cmd,
	input  gbpf_pkg::req_t    req,
	output gbpf_pkg::status_t status,
	output gbpf_pkg::rsp_t    rsp
);

	localparam int XW    = $clog2(GRID_W);
	localparam int YW    = $clog2(GRID_H);
	localparam int AW    = XW + YW;
	localparam int FW    = $clog2(FIFO_DEPTH);
	localparam int QW    = FW + 1;
	localparam int CELLS = GRID_W * GRID_H;
	localparam int LW    = $clog2(CELLS + 1);

	gbpf_pkg::req_t req_q;
	gbpf_pkg::rsp_t rsp_q;
	logic [31:0]    wall_q [gbpf_pkg::WALL_ROWS];
	logic [QW-1:0]  head_q, tail_q;
	logic [LW-1:0]  len_q;
	logic [5:0]     ghost_x_q, ghost_y_q, prev_x_q, prev_y_q;
	logic [YW-1:0]  clr_q;
	gbpf_pkg::dir_t dir_q;
	logic [XW-1:0]  cx_q;
	logic [YW-1:0]  cy_q;
	logic           found_q, stepv_q, target_wall_q;

	// Decoded search coordinates, 0-based.
	logic          coords_ok;
	logic [XW-1:0] sx, tx;
	logic [YW-1:0] sy, ty;

	assign coords_ok = (req_q.start_x != 6'd0) && ({1'b0, req_q.start_x} <= 7'(GRID_W)) &&
		(req_q.start_y != 6'd0) && ({1'b0, req_q.start_y} <= 7'(GRID_H)) &&
		(req_q.target_x != 6'd0) && ({1'b0, req_q.target_x} <= 7'(GRID_W)) &&
		(req_q.target_y != 6'd0) && ({1'b0, req_q.target_y} <= 7'(GRID_H));
	assign sx = XW'(req_q.start_x - 6'd1);
	assign sy = YW'(req_q.start_y - 6'd1);
	assign tx = XW'(req_q.target_x - 6'd1);
	assign ty = YW'(req_q.target_y - 6'd1);

	// Wall word of the row under the clearing sweep; missing rows and columns are open.
	logic [5:0]        clr_row6;
	logic [31:0]       wall_sel;
	logic [GRID_W-1:0] clr_word;

	assign clr_row6 = 6'(clr_q);
	assign wall_sel = (clr_row6 < 6'(gbpf_pkg::WALL_ROWS)) ? wall_q[clr_row6[4:0]] : '0;

	for (genvar j = 0; j < GRID_W; j++) begin : g_col
		if (j < gbpf_pkg::WALL_COLS) begin : g_in
			assign clr_word[j] = wall_sel[j];
		end else begin : g_out
			assign clr_word[j] = 1'b0;
		end
	end

	// Neighbor of the current cell in direction dir_q.
	logic [XW-1:0] nx, px;
	logic [YW-1:0] ny, py;
	logic          nb_oob, par_oob;
	logic [1:0]    par_rdata;

	always_comb begin
		nx     = cx_q;
		ny     = cy_q;
		nb_oob = 1'b0;
		unique case (dir_q)
			gbpf_pkg::DIR_UP: begin
				if (cy_q == '0) nb_oob = 1'b1;
				else ny = cy_q - YW'(1);
			end
			gbpf_pkg::DIR_LEFT: begin
				if (cx_q == '0) nb_oob = 1'b1;
				else nx = cx_q - XW'(1);
			end
			gbpf_pkg::DIR_DOWN: begin
				if (cy_q == YW'(GRID_H - 1)) nb_oob = 1'b1;
				else ny = cy_q + YW'(1);
			end
			gbpf_pkg::DIR_RIGHT: begin
				if (cx_q == XW'(GRID_W - 1)) nb_oob = 1'b1;
				else nx = cx_q + XW'(1);
			end
			default: nb_oob = 1'b1;
		endcase
	end

	// Parent of the current cell: step against the stored direction.
	always_comb begin
		px      = cx_q;
		py      = cy_q;
		par_oob = 1'b0;
		unique case (gbpf_pkg::dir_t'(par_rdata))
			gbpf_pkg::DIR_UP: begin
				if (cy_q == YW'(GRID_H - 1)) par_oob = 1'b1;
				else py = cy_q + YW'(1);
			end
			gbpf_pkg::DIR_LEFT: begin
				if (cx_q == XW'(GRID_W - 1)) par_oob = 1'b1;
				else px = cx_q + XW'(1);
			end
			gbpf_pkg::DIR_DOWN: begin
				if (cy_q == '0) par_oob = 1'b1;
				else py = cy_q - YW'(1);
			end
			gbpf_pkg::DIR_RIGHT: begin
				if (cx_q == '0) par_oob = 1'b1;
				else px = cx_q - XW'(1);
			end
			default: par_oob = 1'b1;
		endcase
	end

	// Visited rows.
	logic              vis_we;
	logic [YW-1:0]     vis_waddr, vis_raddr;
	logic [GRID_W-1:0] vis_wdata, vis_rdata;
	logic              nb_new, fifo_room;

	assign nb_new    = cmd.nb_mark && !vis_rdata[nx];
	assign fifo_room = tail_q < QW'(FIFO_DEPTH);
	assign vis_raddr = cmd.start_rd ? sy : (cmd.nb_issue ? ny : ty);
	assign vis_we    = cmd.clr_step || cmd.push_start || nb_new;
	assign vis_waddr = cmd.clr_step ? clr_q : (cmd.push_start ? sy : ny);
	assign vis_wdata = cmd.clr_step ? clr_word :
		(cmd.push_start ? (vis_rdata | (GRID_W'(1) << sx)) : (vis_rdata | (GRID_W'(1) << nx)));

	gbpf_ram #(.WIDTH(GRID_W), .DEPTH(1 << YW)) u_vis (
		.clk   (clk),
		.we    (vis_we),
		.waddr (vis_waddr),
		.wdata (vis_wdata),
		.raddr (vis_raddr),
		.rdata (vis_rdata)
	);

	gbpf_ram #(.WIDTH(2), .DEPTH(1 << AW)) u_par (
		.clk   (clk),
		.we    (nb_new),
		.waddr ({ny, nx}),
		.wdata (dir_q),
		.raddr ({cy_q, cx_q}),
		.rdata (par_rdata)
	);

	logic          fifo_we;
	logic [AW-1:0] fifo_wdata, fifo_rdata;

	assign fifo_we    = cmd.push_start || (nb_new && fifo_room);
	assign fifo_wdata = cmd.push_start ? {sy, sx} : {ny, nx};

	gbpf_ram #(.WIDTH(AW), .DEPTH(FIFO_DEPTH)) u_fifo (
		.clk   (clk),
		.we    (fifo_we),
		.waddr (FW'(tail_q)),
		.wdata (fifo_wdata),
		.raddr (FW'(head_q)),
		.rdata (fifo_rdata)
	);

	logic          path_we;
	logic [AW-1:0] path_waddr, path_wdata, path_rdata;

	assign path_we    = cmd.trace_start || cmd.trace_take;
	assign path_waddr = cmd.trace_start ? '0 : AW'(len_q);
	assign path_wdata = cmd.trace_start ? {ty, tx} : {py, px};

	gbpf_ram #(.WIDTH(AW), .DEPTH(1 << AW)) u_path (
		.clk   (clk),
		.we    (path_we),
		.waddr (path_waddr),
		.wdata (path_wdata),
		.raddr (AW'(len_q - LW'(1))),
		.rdata (path_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= req;
		end
		if (cmd.out_load) begin
			rsp_q.found      <= found_q;
			rsp_q.step_valid <= stepv_q;
			rsp_q.pos_x      <= ghost_x_q;
			rsp_q.pos_y      <= ghost_y_q;
			rsp_q.prev_x     <= prev_x_q;
			rsp_q.prev_y     <= prev_y_q;
			rsp_q.steps_left <= 11'(len_q);
		end
		if (cmd.clr_step && clr_q == ty) begin
			target_wall_q <= clr_word[tx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < gbpf_pkg::WALL_ROWS; r++) begin
				wall_q[r] <= '0;
			end
			head_q    <= '0;
			tail_q    <= '0;
			len_q     <= '0;
			ghost_x_q <= '0;
			ghost_y_q <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			clr_q     <= '0;
			dir_q     <= gbpf_pkg::DIR_UP;
			cx_q      <= '0;
			cy_q      <= '0;
			found_q   <= 1'b0;
			stepv_q   <= 1'b0;
		end else begin
			if (cmd.latch) begin
				found_q  <= 1'b0;
				stepv_q  <= 1'b0;
				prev_x_q <= ghost_x_q;
				prev_y_q <= ghost_y_q;
				clr_q    <= '0;
				if (req.req_type == gbpf_pkg::REQ_SEARCH) begin
					len_q  <= '0;
					head_q <= '0;
					tail_q <= '0;
				end
			end
			if (cmd.load_row && ({2'b0, req_q.row_index} < 7'(GRID_H))) begin
				wall_q[req_q.row_index] <= req_q.wall_row;
			end
			if (cmd.clr_step) begin
				clr_q <= clr_q + YW'(1);
			end
			if (cmd.push_start) begin
				tail_q <= QW'(1);
			end
			if (cmd.pop_take) begin
				cx_q   <= fifo_rdata[XW-1:0];
				cy_q   <= fifo_rdata[AW-1:XW];
				head_q <= head_q + QW'(1);
				dir_q  <= gbpf_pkg::DIR_UP;
			end
			if (cmd.nb_next) begin
				dir_q <= gbpf_pkg::dir_t'(dir_q + 2'd1);
			end
			if (nb_new && fifo_room) begin
				tail_q <= tail_q + QW'(1);
			end
			if (cmd.trace_start) begin
				len_q   <= LW'(1);
				cx_q    <= tx;
				cy_q    <= ty;
				found_q <= 1'b1;
			end
			if (cmd.trace_take) begin
				len_q <= len_q + LW'(1);
				cx_q  <= px;
				cy_q  <= py;
			end
			if (cmd.step_issue) begin
				len_q <= len_q - LW'(1);
			end
			if (cmd.step_take) begin
				ghost_x_q <= 6'(7'(path_rdata[XW-1:0]) + 7'd1);
				ghost_y_q <= 6'(7'(path_rdata[AW-1:XW]) + 7'd1);
				stepv_q   <= 1'b1;
			end
		end
	end

	assign status.req_type    = req_q.req_type;
	assign status.coords_bad  = !coords_ok;
	assign status.clr_last    = clr_q == YW'(GRID_H - 1);
	assign status.target_wall = target_wall_q;
	assign status.fifo_empty  = head_q == tail_q;
	assign status.target_hit  = vis_rdata[tx];
	assign status.nb_oob      = nb_oob;
	assign status.dir_last    = dir_q == gbpf_pkg::DIR_RIGHT;
	assign status.trace_done  = ({cy_q, cx_q} == {sy, sx}) || (len_q >= LW'(CELLS));
	assign status.trace_oob   = par_oob;
	assign status.path_empty  = len_q == '0;

	assign rsp = rsp_q;

endmodule

FILE: rtl/grid_bfs_path_finder_top.sv
// Grid path finder: breadth-first search on a wall map, with a held ghost position.
// Request channel (req_valid / req_stall / req) takes one item at a time: a wall row
// load, a search from start to target, or a step along the stored path.
// Response channel (rsp_valid / rsp_stall / rsp) returns exactly one result per item.
// Search: a visited-row clearing sweep, then for each popped cell a test of each
// neighbor on the grid, then a trace back along the stored parents. The cost is
// set by the single read port of the visited-row RAM, one access per neighbor test.
// A new item is taken only once the previous result has left the output register;
// while rsp_stall is high the result holds and req_stall stays high.
// Reset opens every wall cell, empties the path and puts the ghost at (0, 0);
// visited marks, parent and queue RAMs are rewritten by each search before use.
module grid_bfs_path_finder_top #(
	parameter int GRID_W     = gbpf_pkg::GRID_W,
	parameter int GRID_H     = gbpf_pkg::GRID_H,
	parameter int FIFO_DEPTH = gbpf_pkg::FIFO_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  gbpf_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output gbpf_pkg::rsp_t rsp
);

	gbpf_pkg::cmd_t    cmd;
	gbpf_pkg::status_t status;

	gbpf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.cmd       (cmd)
	);

	gbpf_dp #(
		.GRID_W     (GRID_W),
		.GRID_H     (GRID_H),
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.status (status),
		.rsp    (rsp)
	);

endmodule

FILE: rtl/gbpf_checker.sv
`include "grid_bfs_path_finder_top_assert.svh"

module gbpf_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input gbpf_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input gbpf_pkg::rsp_t rsp
);

	`GBPF_ASSERT(a_one_item, req_valid && !req_stall |=> req_stall, "item taken while busy")
	`GBPF_ASSERT_HOLD(a_rsp_hold, rsp_valid && rsp_stall, rsp, "stalled result changed")
	`GBPF_ASSERT(a_excl, rsp_valid |-> !(rsp.found && rsp.step_valid), "found and step both set")
	`GBPF_ASSERT(a_ghost, rsp_valid && !rsp.step_valid |-> rsp.pos_x == rsp.prev_x && rsp.pos_y == rsp.prev_y, "ghost moved without a step")

endmodule

bind grid_bfs_path_finder_top gbpf_checker u_chk (.*);
